// ===== src/emeg_pkg.sv =====
// Shared constants, sine table and rounding helpers for the ellipsoid mesh element generator.
`default_nettype none
package emeg_pkg;

    localparam int MAX_COLUMNS   = 256;
    localparam int MAX_RINGS     = 256;
    localparam int TRIG_BITS     = 10;
    localparam int TRIG_SIZE     = 1 << TRIG_BITS;
    localparam int TRIG_QUARTER  = TRIG_SIZE / 4;
    localparam int QIDX_W        = TRIG_BITS - 2;
    localparam int TRIG_EPS      = 2;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    // long division: 16 quotient bits, four per register stage
    localparam int DIV_STEPS     = 16;
    localparam int DIV_STAGES    = 4;
    localparam int DIV_PER_STAGE = DIV_STEPS / DIV_STAGES;

    // sine lookup, two multiply/round pairs
    localparam int SHADE_STAGES  = 5;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RINGS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_H = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_V = 2'd3;

    localparam logic OP_VERTEX   = 1'b0;
    localparam logic OP_TRIANGLE = 1'b1;

    typedef logic [14:0] t_qrom [TRIG_QUARTER];

    // sin(pi/2 * r / quarter) in Q1.14 by a Taylor series, evaluated at elaboration
    function automatic logic [14:0] quarter_sine(input int unsigned r);
        longint unsigned theta;
        longint unsigned t2;
        longint unsigned p;
        longint unsigned v;
        theta = (64'(r) * HALF_PI_Q30) / 64'(TRIG_QUARTER);
        t2    = (theta * theta) >> 30;
        p     = ONE_Q30;
        p     = ONE_Q30 - ((t2 * p) >> 30) / 64'd110;
        p     = ONE_Q30 - ((t2 * p) >> 30) / 64'd72;
        p     = ONE_Q30 - ((t2 * p) >> 30) / 64'd42;
        p     = ONE_Q30 - ((t2 * p) >> 30) / 64'd20;
        p     = ONE_Q30 - ((t2 * p) >> 30) / 64'd6;
        v     = (((theta * p) >> 30) + (64'd1 << 15)) >> 16;
        return 15'(v);
    endfunction

    function automatic t_qrom build_qrom();
        t_qrom rom;
        for (int r = 0; r < TRIG_QUARTER; r++) begin
            rom[r] = quarter_sine(r);
            if (rom[r] < 15'(TRIG_EPS)) begin
                rom[r] = '0;
            end
        end
        return rom;
    endfunction

    localparam t_qrom       QROM = build_qrom();
    localparam logic [14:0] QTOP = quarter_sine(TRIG_QUARTER);

    // full-turn sine from the quarter-wave table
    function automatic logic signed [15:0] table_sine(input logic [TRIG_BITS-1:0] ph);
        logic [1:0]        quad;
        logic [QIDX_W-1:0] r;
        logic [QIDX_W-1:0] rr;
        logic [14:0]       mag;
        quad = ph[TRIG_BITS-1 -: 2];
        r    = ph[QIDX_W-1:0];
        rr   = '0 - r;
        if (quad[0] && (r == '0)) begin
            mag = QTOP;
        end else if (quad[0]) begin
            mag = QROM[rr];
        end else begin
            mag = QROM[r];
        end
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // shift right by 14, round to nearest, ties away from zero
    function automatic logic signed [33:0] round14(input logic signed [33:0] v);
        logic [33:0] mag;
        mag = v[33] ? 34'(-v) : 34'(v);
        mag = (mag + 34'd8192) >> 14;
        return v[33] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage
`default_nettype wire

// ===== src/emeg_if.sv =====
// Request and result channel interfaces.
`default_nettype none
interface emeg_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [16:0] element_number;
    modport source (output valid, opcode, element_number, input ready);
    modport sink   (input valid, opcode, element_number, output ready);
endinterface

interface emeg_res_if;
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic signed [17:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [15:0]        corner_a;
    logic [15:0]        corner_b;
    logic [15:0]        corner_c;
    modport source (output valid, valid_res, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    tex_u, tex_v, corner_a, corner_b, corner_c, input ready);
    modport sink   (input valid, valid_res, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    tex_u, tex_v, corner_a, corner_b, corner_c, output ready);
endinterface
`default_nettype wire

// ===== src/emeg_divlane.sv =====
// Pipelined restoring divider lane: 16 quotient bits over four register stages.
`default_nettype none
module emeg_divlane
    import emeg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [8:0]  i_rem,
    input  logic [15:0] i_num,
    input  logic [8:0]  i_den,
    output logic [15:0] o_quo,
    output logic [8:0]  o_rem
);

    logic [8:0]  r_rem [DIV_STAGES];
    logic [15:0] r_num [DIV_STAGES];
    logic [8:0]  n_rem [DIV_STAGES];
    logic [15:0] n_num [DIV_STAGES];

    // shift one numerator bit into the remainder, subtract when it fits
    always_comb begin
        logic [9:0]  tmp;
        logic [8:0]  rem;
        logic [15:0] num;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                rem = i_rem;
                num = i_num;
            end else begin
                rem = r_rem[s-1];
                num = r_num[s-1];
            end
            for (int j = 0; j < DIV_PER_STAGE; j++) begin
                tmp = {rem, num[15]};
                if (tmp >= {1'b0, i_den}) begin
                    rem = 9'(tmp - {1'b0, i_den});
                    num = {num[14:0], 1'b1};
                end else begin
                    rem = tmp[8:0];
                    num = {num[14:0], 1'b0};
                end
            end
            n_rem[s] = rem;
            n_num[s] = num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_num[s] <= n_num[s];
            end
        end
    end

    assign o_quo = r_num[DIV_STAGES-1];
    assign o_rem = r_rem[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== src/emeg_shade.sv =====
// Normal and position datapath: sine lookup, two multiply and round pairs.
`default_nettype none
module emeg_shade
    import emeg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [TRIG_BITS-1:0]  i_phx,
    input  logic [TRIG_BITS-1:0]  i_phy,
    input  logic [15:0]           i_rh,
    input  logic [15:0]           i_rv,
    output logic signed [15:0]    o_nx,
    output logic signed [15:0]    o_ny,
    output logic signed [15:0]    o_nz,
    output logic signed [17:0]    o_px,
    output logic signed [17:0]    o_py,
    output logic signed [17:0]    o_pz
);

    logic signed [15:0] r_sx, r_cx, r_sy, r_cy;
    logic signed [31:0] r_ax, r_az;
    logic signed [15:0] r_sy2;
    logic signed [15:0] r_nx3, r_ny3, r_nz3;
    logic signed [32:0] r_qx, r_qy, r_qz;
    logic signed [15:0] r_nx4, r_ny4, r_nz4;
    logic signed [17:0] r_px, r_py, r_pz;
    logic signed [15:0] r_nx5, r_ny5, r_nz5;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx  <= table_sine(i_phx);
            r_cx  <= table_sine(i_phx + TRIG_BITS'(TRIG_QUARTER));
            r_sy  <= table_sine(i_phy);
            r_cy  <= table_sine(i_phy + TRIG_BITS'(TRIG_QUARTER));

            r_ax  <= r_sx * r_cy;
            r_az  <= r_cx * r_cy;
            r_sy2 <= r_sy;

            r_nx3 <= 16'(round14(34'(r_ax)));
            r_nz3 <= 16'(round14(34'(r_az)));
            r_ny3 <= r_sy2;

            r_qx  <= r_nx3 * $signed({1'b0, i_rh});
            r_qz  <= r_nz3 * $signed({1'b0, i_rh});
            r_qy  <= r_ny3 * $signed({1'b0, i_rv});
            r_nx4 <= r_nx3;
            r_ny4 <= r_ny3;
            r_nz4 <= r_nz3;

            r_px  <= 18'(round14(34'(r_qx)));
            r_py  <= 18'(round14(34'(r_qy)));
            r_pz  <= 18'(round14(34'(r_qz)));
            r_nx5 <= r_nx4;
            r_ny5 <= r_ny4;
            r_nz5 <= r_nz4;
        end
    end

    assign o_nx = r_nx5;
    assign o_ny = r_ny5;
    assign o_nz = r_nz5;
    assign o_px = r_px;
    assign o_py = r_py;
    assign o_pz = r_pz;

endmodule
`default_nettype wire

// ===== src/ellipsoid_mesh_element_generator_unit.sv =====
// UV ellipsoid mesh element generator, top level.
// Throughput: one request word per cycle unless a result word held at the output stalls the pipe;
// two chained 16-step dividers (four stages each) and the five-stage normal/position
// datapath set the depth, all stages advance together.
// Reset (synchronous, active low) empties the pipeline and restores 16 columns,
// 8 rings and both radii at 1.0.
`default_nettype none
module ellipsoid_mesh_element_generator_unit
    import emeg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    emeg_req_if.sink             i_req,
    emeg_res_if.source           o_res
);

    typedef struct packed {
        logic        vld;
        logic        op;
        logic        inr;
        logic        npole;
        logic        spole;
        logic        band;
        logic        par;
        logic [15:0] ca;
        logic [15:0] cb;
        logic [15:0] cc;
    } t_side_a;

    typedef struct packed {
        logic        vld;
        logic        op;
        logic        inr;
        logic        npole;
        logic        spole;
        logic        tvz;
        logic [15:0] ca;
        logic [15:0] cb;
        logic [15:0] cc;
    } t_side_b;

    typedef struct packed {
        t_side_b     sb;
        logic [15:0] tu;
        logic [15:0] tv;
    } t_side_c;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [8:0]  r_col_cnt, r_ring_cnt;
    logic [15:0] r_rad_h, r_rad_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt  <= 9'd16;
            r_ring_cnt <= 9'd8;
            r_rad_h    <= 16'd256;
            r_rad_v    <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLUMNS:  r_col_cnt  <= i_cfg_data[8:0];
                CFG_RINGS:    r_ring_cnt <= i_cfg_data[8:0];
                CFG_RADIUS_H: r_rad_h    <= i_cfg_data;
                CFG_RADIUS_V: r_rad_v    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Mesh sizes derived from the clamped counts, registered behind the configuration
    // registers; a request only reaches them from the input register after it is accepted.
    logic [8:0]  cols, rows;
    logic [16:0] prod_v;
    logic [8:0]  r_cols, r_rows;
    logic [16:0] r_vcount, r_south, r_tcount, r_band;
    logic [15:0] r_w0b;
    logic [7:0]  r_hc, r_hr;

    always_comb begin
        if (r_col_cnt < 9'd3) begin
            cols = 9'd3;
        end else if (r_col_cnt > 9'(MAX_COLUMNS)) begin
            cols = 9'(MAX_COLUMNS);
        end else begin
            cols = r_col_cnt;
        end
        if (r_ring_cnt < 9'd2) begin
            rows = 9'd2;
        end else if (r_ring_cnt > 9'(MAX_RINGS)) begin
            rows = 9'(MAX_RINGS);
        end else begin
            rows = r_ring_cnt;
        end
        prod_v = 17'(cols) * 17'(rows - 9'd1);
    end

    always_ff @(posedge i_clk) begin
        r_cols   <= cols;
        r_rows   <= rows;
        r_vcount <= prod_v + 17'd2;
        r_south  <= prod_v + 17'd1;
        r_tcount <= {prod_v[15:0], 1'b0};
        r_band   <= 17'({prod_v - 17'(cols), 1'b0});
        r_w0b    <= 16'(prod_v - 17'(cols) + 17'd1);
        r_hc     <= 8'(cols >> 1);
        r_hr     <= 8'(rows >> 1);
    end

    // ---------------------------------------------------------------------
    // Global advance: the whole pipe moves when the output register is free
    // ---------------------------------------------------------------------
    logic r_out_vld;
    logic en;

    assign en          = !r_out_vld || o_res.ready;
    assign i_req.ready = en;

    // Input register
    logic        r_p0_vld;
    logic        r_p0_op;
    logic [16:0] r_p0_n;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0_op <= i_req.opcode;
            r_p0_n  <= i_req.element_number;
        end
        if (!i_rst_n) begin
            r_p0_vld <= 1'b0;
        end else if (en) begin
            r_p0_vld <= i_req.valid;
        end
    end

    // ---------------------------------------------------------------------
    // Classify: range check, poles, cap corners, numerator of the first division
    // ---------------------------------------------------------------------
    t_side_a     n_sa;
    logic [15:0] n_numa;

    always_comb begin
        logic [16:0] m;
        logic [16:0] xb;
        m  = r_p0_n - 17'(r_cols);
        xb = m - r_band;
        n_sa.vld   = r_p0_vld;
        n_sa.op    = r_p0_op;
        n_sa.npole = (r_p0_n == '0);
        n_sa.spole = (r_p0_n == r_south);
        n_sa.band  = (r_p0_n >= 17'(r_cols)) && (m < r_band);
        n_sa.par   = m[0];
        if (r_p0_op == OP_VERTEX) begin
            n_sa.inr = (r_p0_n < r_vcount);
            n_numa   = 16'(r_p0_n - 17'd1);
        end else begin
            n_sa.inr = (r_p0_n < r_tcount);
            // band rows hold 2*cols triangles: divide the pair number by cols
            n_numa   = m[16:1];
        end
        if (r_p0_n < 17'(r_cols)) begin
            // top cap fan around the north pole, last one wraps to column 0
            n_sa.ca = '0;
            n_sa.cb = 16'(r_p0_n + 17'd1);
            n_sa.cc = (r_p0_n == 17'(r_cols) - 17'd1) ? 16'd1 : 16'(r_p0_n + 17'd2);
        end else begin
            // bottom cap fan around the south pole
            n_sa.ca = 16'(r_south);
            n_sa.cb = (xb == 17'(r_cols) - 17'd1) ? r_w0b : 16'(xb + 17'(r_w0b) + 17'd1);
            n_sa.cc = 16'(xb + 17'(r_w0b));
        end
    end

    t_side_a     r_sa [DIV_STAGES+1];
    logic [15:0] r_numa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DIV_STAGES; i++) begin
                r_sa[i].vld <= 1'b0;
            end
        end else if (en) begin
            r_numa  <= n_numa;
            r_sa[0] <= n_sa;
            for (int i = 1; i <= DIV_STAGES; i++) begin
                r_sa[i] <= r_sa[i-1];
            end
        end
    end

    // Ring and column split (vertex) or band row and pair (triangle)
    logic [15:0] qa;
    logic [8:0]  ra;

    emeg_divlane u_div_ring (
        .i_clk (i_clk),
        .i_en  (en),
        .i_rem ('0),
        .i_num (r_numa),
        .i_den (r_cols),
        .o_quo (qa),
        .o_rem (ra)
    );

    // ---------------------------------------------------------------------
    // Band corners and texture/phase numerators
    // ---------------------------------------------------------------------
    t_side_a     sa;
    t_side_b     n_sb;
    logic [8:0]  n_tu_rem, n_px_rem, n_py_rem, n_tv_rem;
    logic [15:0] n_px_num, n_py_num;

    assign sa = r_sa[DIV_STAGES];

    always_comb begin
        logic [7:0]  vx;
        logic [8:0]  vy;
        logic [7:0]  ty;
        logic [8:0]  tx;
        logic [16:0] w0, w1, va, vb, vc, vd;
        logic [23:0] nphx, nphy;
        vx = ra[7:0];
        vy = 9'(qa[7:0]) + 9'd1;
        ty = qa[7:0];
        tx = 9'(ra[7:0]) + 9'd1;
        w0 = 17'(r_cols) * 17'(ty);
        w1 = w0 + 17'(r_cols);
        va = w0 + 17'(tx);
        vc = w1 + 17'(tx);
        // last pair of a band wraps to column 0 of both rings
        vd = (tx == r_cols) ? w1 + 17'd1 : vc + 17'd1;
        vb = (tx == r_cols) ? w0 + 17'd1 : va + 17'd1;

        n_sb.vld   = sa.vld;
        n_sb.op    = sa.op;
        n_sb.inr   = sa.inr;
        n_sb.npole = sa.npole;
        n_sb.spole = sa.spole;
        n_sb.tvz   = (qa == '0);
        if ((sa.op == OP_TRIANGLE) && sa.band) begin
            if (!sa.par) begin
                n_sb.ca = 16'(va);
                n_sb.cb = 16'(vc);
                n_sb.cc = 16'(vd);
            end else begin
                n_sb.ca = 16'(vd);
                n_sb.cb = 16'(vb);
                n_sb.cc = 16'(va);
            end
        end else begin
            n_sb.ca = sa.ca;
            n_sb.cb = sa.cb;
            n_sb.cc = sa.cc;
        end

        // rounded phases: (x*size + cols/2) / cols, (y*size/2 + rows/2) / rows
        nphx     = (24'(vx) << TRIG_BITS) + 24'(r_hc);
        nphy     = (24'(vy) << (TRIG_BITS - 1)) + 24'(r_hr);
        n_tu_rem = 9'(vx);
        n_tv_rem = vy;
        n_px_rem = 9'(nphx >> 16);
        n_px_num = nphx[15:0];
        n_py_rem = 9'(nphy >> 16);
        n_py_num = nphy[15:0];
    end

    t_side_b     r_sb [DIV_STAGES+1];
    logic [8:0]  r_tu_rem, r_px_rem, r_py_rem, r_tv_rem;
    logic [15:0] r_px_num, r_py_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DIV_STAGES; i++) begin
                r_sb[i].vld <= 1'b0;
            end
        end else if (en) begin
            r_tu_rem <= n_tu_rem;
            r_tv_rem <= n_tv_rem;
            r_px_rem <= n_px_rem;
            r_px_num <= n_px_num;
            r_py_rem <= n_py_rem;
            r_py_num <= n_py_num;
            r_sb[0]  <= n_sb;
            for (int i = 1; i <= DIV_STAGES; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
        end
    end

    logic [15:0] quo_tu, quo_tv, quo_px, quo_py;
    logic [8:0]  rem_tu, rem_tv, rem_px, rem_py;

    emeg_divlane u_div_tu (
        .i_clk (i_clk), .i_en (en), .i_rem (r_tu_rem), .i_num ('0),
        .i_den (r_cols), .o_quo (quo_tu), .o_rem (rem_tu)
    );

    emeg_divlane u_div_tv (
        .i_clk (i_clk), .i_en (en), .i_rem (r_tv_rem), .i_num ('0),
        .i_den (r_rows), .o_quo (quo_tv), .o_rem (rem_tv)
    );

    emeg_divlane u_div_phx (
        .i_clk (i_clk), .i_en (en), .i_rem (r_px_rem), .i_num (r_px_num),
        .i_den (r_cols), .o_quo (quo_px), .o_rem (rem_px)
    );

    emeg_divlane u_div_phy (
        .i_clk (i_clk), .i_en (en), .i_rem (r_py_rem), .i_num (r_py_num),
        .i_den (r_rows), .o_quo (quo_py), .o_rem (rem_py)
    );

    // ---------------------------------------------------------------------
    // Normal and position; texture and corners ride alongside
    // ---------------------------------------------------------------------
    t_side_c n_sc;
    logic    rem_unused;

    // remainders of the texture and phase lanes carry no information
    assign rem_unused = ^{rem_tu, rem_tv, rem_px, rem_py};

    always_comb begin
        n_sc.sb = r_sb[DIV_STAGES];
        n_sc.tu = quo_tu;
        // first ring keeps v at zero
        n_sc.tv = (r_sb[DIV_STAGES].tvz || rem_unused && 1'b0) ? 16'd0 : quo_tv;
    end

    logic signed [15:0] s_nx, s_ny, s_nz;
    logic signed [17:0] s_px, s_py, s_pz;

    emeg_shade u_shade (
        .i_clk (i_clk),
        .i_en  (en),
        .i_phx (quo_px[TRIG_BITS-1:0]),
        .i_phy (quo_py[TRIG_BITS-1:0] + TRIG_BITS'(TRIG_QUARTER)),
        .i_rh  (r_rad_h),
        .i_rv  (r_rad_v),
        .o_nx  (s_nx),
        .o_ny  (s_ny),
        .o_nz  (s_nz),
        .o_px  (s_px),
        .o_py  (s_py),
        .o_pz  (s_pz)
    );

    t_side_c r_sc [SHADE_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SHADE_STAGES; i++) begin
                r_sc[i].sb.vld <= 1'b0;
            end
        end else if (en) begin
            r_sc[0] <= n_sc;
            for (int i = 1; i < SHADE_STAGES; i++) begin
                r_sc[i] <= r_sc[i-1];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output register: assemble the word, zero what does not apply
    // ---------------------------------------------------------------------
    t_side_c            sc;
    logic               n_valid_res;
    logic signed [17:0] n_pos_x, n_pos_y, n_pos_z;
    logic signed [15:0] n_norm_x, n_norm_y, n_norm_z;
    logic [15:0]        n_tex_u, n_tex_v, n_corner_a, n_corner_b, n_corner_c;
    logic               r_valid_res;
    logic signed [17:0] r_pos_x, r_pos_y, r_pos_z;
    logic signed [15:0] r_norm_x, r_norm_y, r_norm_z;
    logic [15:0]        r_tex_u, r_tex_v, r_corner_a, r_corner_b, r_corner_c;

    assign sc = r_sc[SHADE_STAGES-1];

    always_comb begin
        n_valid_res = 1'b0;
        n_pos_x     = '0;
        n_pos_y     = '0;
        n_pos_z     = '0;
        n_norm_x    = '0;
        n_norm_y    = '0;
        n_norm_z    = '0;
        n_tex_u     = '0;
        n_tex_v     = '0;
        n_corner_a  = '0;
        n_corner_b  = '0;
        n_corner_c  = '0;
        if (sc.sb.inr) begin
            n_valid_res = 1'b1;
            if (sc.sb.op == OP_VERTEX) begin
                if (sc.sb.npole) begin
                    n_pos_y  = $signed({2'b00, r_rad_v});
                    n_norm_y = ONE_Q14;
                end else if (sc.sb.spole) begin
                    n_pos_y  = -$signed({2'b00, r_rad_v});
                    n_norm_y = -ONE_Q14;
                end else begin
                    n_pos_x  = s_px;
                    n_pos_y  = s_py;
                    n_pos_z  = s_pz;
                    n_norm_x = s_nx;
                    n_norm_y = s_ny;
                    n_norm_z = s_nz;
                    n_tex_u  = sc.tu;
                    n_tex_v  = sc.tv;
                end
            end else begin
                n_corner_a = sc.sb.ca;
                n_corner_b = sc.sb.cb;
                n_corner_c = sc.sb.cc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_valid_res <= n_valid_res;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_pos_z     <= n_pos_z;
            r_norm_x    <= n_norm_x;
            r_norm_y    <= n_norm_y;
            r_norm_z    <= n_norm_z;
            r_tex_u     <= n_tex_u;
            r_tex_v     <= n_tex_v;
            r_corner_a  <= n_corner_a;
            r_corner_b  <= n_corner_b;
            r_corner_c  <= n_corner_c;
        end
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= sc.sb.vld;
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.valid_res = r_valid_res;
    assign o_res.pos_x     = r_pos_x;
    assign o_res.pos_y     = r_pos_y;
    assign o_res.pos_z     = r_pos_z;
    assign o_res.norm_x    = r_norm_x;
    assign o_res.norm_y    = r_norm_y;
    assign o_res.norm_z    = r_norm_z;
    assign o_res.tex_u     = r_tex_u;
    assign o_res.tex_v     = r_tex_v;
    assign o_res.corner_a  = r_corner_a;
    assign o_res.corner_b  = r_corner_b;
    assign o_res.corner_c  = r_corner_c;

endmodule
`default_nettype wire

// ===== dv/ellipsoid_mesh_element_generator_unit_tb.sv =====
// Self-checking testbench for the ellipsoid mesh element generator: directed and random requests.
`timescale 1ns / 1ps
module ellipsoid_mesh_element_generator_unit_tb;
    import emeg_pkg::*;

    // one expected result word
    typedef struct packed {
        logic               valid_res;
        logic signed [17:0] pos_x;
        logic signed [17:0] pos_y;
        logic signed [17:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [15:0]        corner_a;
        logic [15:0]        corner_b;
        logic [15:0]        corner_c;
    } t_mesh_word;

    localparam int LIMIT_CYCLES = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0] i_cfg_data;

    emeg_req_if req_ch ();
    emeg_res_if res_ch ();

    ellipsoid_mesh_element_generator_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_res      (res_ch.source)
    );

    // shadow copy of the configuration registers
    int unsigned cfg_cols;
    int unsigned cfg_rings;
    int unsigned cfg_rad_h;
    int unsigned cfg_rad_v;

    t_mesh_word  expected_words[$];
    int          mismatch_count;
    int unsigned cycle_count;
    bit          sink_stalls_on;
    bit          source_gaps_on;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("ellipsoid_mesh_element_generator_unit regression: fail");
            $finish;
        end
    end

    // counts as the block sees them after saturation
    function automatic int unsigned mesh_cols();
        return cfg_cols < 3 ? 3 : (cfg_cols > MAX_COLUMNS ? MAX_COLUMNS : cfg_cols);
    endfunction

    function automatic int unsigned mesh_rows();
        return cfg_rings < 2 ? 2 : (cfg_rings > MAX_RINGS ? MAX_RINGS : cfg_rings);
    endfunction

    // independent sine: quarter wave by series, small values forced to zero
    function automatic longint quarter_wave(int unsigned r);
        longint unsigned th, t2, p;
        th = (64'(r) * 64'd1686629713) / 64'(TRIG_QUARTER);
        t2 = (th * th) >> 30;
        p = 64'd1 << 30;
        for (int n = 10; n >= 2; n -= 2)
            p = (64'd1 << 30) - ((t2 * p) >> 30) / 64'(n * (n + 1));
        return longint'((((th * p) >> 30) + (64'd1 << 15)) >> 16);
    endfunction

    function automatic longint sine_of_phase(int unsigned phase);
        int unsigned ph, quad, r;
        longint v;
        ph = phase % TRIG_SIZE;
        quad = ph / TRIG_QUARTER;
        r = ph % TRIG_QUARTER;
        v = quad[0] ? quarter_wave(TRIG_QUARTER - r) : quarter_wave(r);
        if (quad[1]) v = -v;
        if (v > -TRIG_EPS && v < TRIG_EPS) v = 0;
        return v;
    endfunction

    function automatic longint shift14_nearest(longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + 8192) >>> 14;
        return (v < 0) ? -m : m;
    endfunction

    // compute the mesh element a request names
    function automatic t_mesh_word mesh_element(bit op, int unsigned n);
        t_mesh_word w;
        int unsigned cols, rows, vcount, tcount, south, band, k, y, x, phx, phy;
        int unsigned m, rem, w0, w1, va, vb, vc, vd, a, b, c;
        longint nx, ny, nz, sy, cy;
        w = '0;
        cols = mesh_cols();
        rows = mesh_rows();
        vcount = (rows - 1) * cols + 2;
        tcount = 2 * cols * (rows - 1);
        south = vcount - 1;
        band = 2 * cols * (rows - 2);
        if (op == OP_VERTEX) begin
            if (n >= vcount) return w;
            w.valid_res = 1'b1;
            if (n == 0 || n == south) begin
                w.norm_y = (n == 0) ? 16'sd16384 : -16'sd16384;
                w.pos_y = (n == 0) ? 18'(cfg_rad_v) : -18'(cfg_rad_v);
            end else begin
                k = n - 1;
                y = k / cols + 1;
                x = k % cols;
                phx = (x * TRIG_SIZE + cols / 2) / cols;
                phy = TRIG_QUARTER + (y * (TRIG_SIZE / 2) + rows / 2) / rows;
                sy = sine_of_phase(phy);
                cy = sine_of_phase(phy + TRIG_QUARTER);
                nx = shift14_nearest(sine_of_phase(phx) * cy);
                nz = shift14_nearest(sine_of_phase(phx + TRIG_QUARTER) * cy);
                ny = sy;
                w.norm_x = 16'(nx);
                w.norm_y = 16'(ny);
                w.norm_z = 16'(nz);
                w.pos_x = 18'(shift14_nearest(nx * longint'(cfg_rad_h)));
                w.pos_z = 18'(shift14_nearest(nz * longint'(cfg_rad_h)));
                w.pos_y = 18'(shift14_nearest(ny * longint'(cfg_rad_v)));
                w.tex_u = 16'((longint'(x) << 16) / cols);
                w.tex_v = (y == 1) ? 16'd0 : 16'((longint'(y) << 16) / rows);
            end
        end else begin
            if (n >= tcount) return w;
            w.valid_res = 1'b1;
            if (n < cols) begin
                a = 0;
                b = n + 1;
                c = (n == cols - 1) ? 1 : n + 2;
            end else if (n - cols < band) begin
                m = n - cols;
                y = m / (2 * cols);
                rem = m % (2 * cols);
                x = rem / 2 + 1;
                w0 = cols * y;
                w1 = cols * (y + 1);
                va = x + w0;
                vc = x + w1;
                vd = (x == cols) ? w1 + 1 : vc + 1;
                vb = (x == cols) ? w0 + 1 : va + 1;
                if (rem[0] == 1'b0) begin
                    a = va; b = vc; c = vd;
                end else begin
                    a = vd; b = vb; c = va;
                end
            end else begin
                x = n - cols - band;
                w0 = cols * (rows - 2) + 1;
                a = south;
                b = (x == cols - 1) ? w0 : x + w0 + 1;
                c = x + w0;
            end
            w.corner_a = 16'(a);
            w.corner_b = 16'(b);
            w.corner_c = 16'(c);
        end
        return w;
    endfunction

    // result sink: random stall bursts
    initial begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                stall = $urandom_range(1, 19);
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    // compare each accepted result word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            t_mesh_word got, want;
            got = {res_ch.valid_res, res_ch.pos_x, res_ch.pos_y, res_ch.pos_z,
                   res_ch.norm_x, res_ch.norm_y, res_ch.norm_z, res_ch.tex_u,
                   res_ch.tex_v, res_ch.corner_a, res_ch.corner_b, res_ch.corner_c};
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result word %h", got);
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // send one request word, with a random gap first when gaps are on
    task automatic send_request(bit op, int unsigned n);
        if (source_gaps_on && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.element_number <= 17'(n);
        expected_words.push_back(mesh_element(op, n & 17'h1FFFF));
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // wait for all results, drain the pipeline, then allow a register write
    task automatic drain_pipeline();
        req_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (24) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 16'(value);
        case (idx)
            CFG_COLUMNS:  cfg_cols = value & 9'h1FF;
            CFG_RINGS:    cfg_rings = value & 9'h1FF;
            CFG_RADIUS_H: cfg_rad_h = value & 16'hFFFF;
            default:      cfg_rad_v = value & 16'hFFFF;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_mesh(int unsigned cols, int unsigned rings, int unsigned rh,
                            int unsigned rv);
        drain_pipeline();
        write_register(CFG_COLUMNS, cols);
        write_register(CFG_RINGS, rings);
        write_register(CFG_RADIUS_H, rh);
        write_register(CFG_RADIUS_V, rv);
    endtask

    // poles, first ring, seams, range edges, extreme field values at reset config
    task automatic test_directed_elements();
        int unsigned fixed_ns[12] = '{0, 1, 16, 17, 112, 113, 114, 200, 131071, 15, 239, 240};
        foreach (fixed_ns[i]) begin
            send_request(OP_VERTEX, fixed_ns[i]);
            send_request(OP_TRIANGLE, fixed_ns[i]);
        end
    endtask

    // each mesh: walk every vertex and triangle of small meshes
    task automatic test_full_sweep(int unsigned cols, int unsigned rings);
        int unsigned nv;
        int unsigned nt;
        set_mesh(cols, rings, $urandom_range(0, 65535), $urandom_range(0, 65535));
        nv = (mesh_rows() - 1) * mesh_cols() + 2;
        nt = 2 * mesh_cols() * (mesh_rows() - 1);
        for (int unsigned n = 0; n <= nt; n++) begin
            if (n <= nv) send_request(OP_VERTEX, n);
            send_request(OP_TRIANGLE, n);
        end
    endtask

    // random requests, mostly in range, some with arbitrary numbers
    task automatic test_random_requests(int count);
        int unsigned span;
        bit op;
        for (int i = 0; i < count; i++) begin
            op = $urandom_range(0, 1);
            span = (op == OP_VERTEX) ? (mesh_rows() - 1) * mesh_cols() + 2
                                     : 2 * mesh_cols() * (mesh_rows() - 1);
            if ($urandom_range(0, 9) == 0) send_request(op, $urandom_range(0, 131071));
            else send_request(op, $urandom_range(0, span + 1));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_COLUMNS;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.opcode = OP_VERTEX;
        req_ch.element_number = '0;
        cfg_cols = 16;
        cfg_rings = 8;
        cfg_rad_h = 256;
        cfg_rad_v = 256;
        mismatch_count = 0;
        cycle_count = 0;
        sink_stalls_on = 1'b1;
        source_gaps_on = 1'b1;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_elements();
        // undersized counts saturate up; small meshes swept with random radii
        test_full_sweep(0, 0);
        test_full_sweep(4, 3);
        set_mesh(256, 256, 65535, 65535);
        test_random_requests(150);
        set_mesh(511, 511, 0, 0);
        test_random_requests(100);
        set_mesh(300, 257, 32768, 1);
        test_random_requests(100);
        set_mesh(7, 5, $urandom_range(0, 65535), $urandom_range(0, 65535));
        test_random_requests(150);
        set_mesh(3, 2, 65535, 0);
        test_random_requests(50);
        // last stretch runs at full rate
        set_mesh($urandom_range(3, 40), $urandom_range(2, 40), $urandom_range(0, 65535),
                 $urandom_range(0, 65535));
        sink_stalls_on = 1'b0;
        source_gaps_on = 1'b0;
        test_random_requests(150);
        drain_pipeline();

        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("ellipsoid_mesh_element_generator_unit regression: pass");
        else
            $display("ellipsoid_mesh_element_generator_unit regression: fail");
        $finish;
    end
endmodule
